@@ design/hhc_pkg.sv @@
package hhc_pkg;

	// Table geometry.
	localparam int SLOTS   = 16;
	localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int USED_W  = $clog2(SLOTS + 1);
	localparam int KEY_W   = 32;
	localparam int CNT_W   = 32;
	localparam int RD_W    = 4;
	localparam int STAT_W  = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Request operation codes.
	localparam logic OP_COUNT = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_HIT    = 2'd0;
	localparam logic [STAT_W-1:0] ST_INSERT = 2'd1;
	localparam logic [STAT_W-1:0] ST_DROP   = 2'd2;
	localparam logic [STAT_W-1:0] ST_READ   = 2'd3;

	// Action broadcast to every cell of the row.
	typedef enum logic [2:0] {
		CA_NONE,
		CA_HIT,
		CA_INSERT,
		CA_DECAY,
		CA_PUSH
	} cell_act_t;

	typedef struct packed {
		cell_act_t        act;
		logic [KEY_W-1:0] key;
		logic [RD_W-1:0]  idx;
		logic [IDX_W-1:0] slot;
	} cell_cmd_t;

	// Data handed from one cell to the next along the row.
	typedef struct packed {
		logic             hit;
		logic             rd_valid;
		logic [KEY_W-1:0] rd_key;
		logic [CNT_W-1:0] rd_count;
		logic             sel_found;
		logic [IDX_W-1:0] sel_idx;
	} cell_chain_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_DECAY,
		S_PUSH
	} hhc_state_t;

	// Free list ring pointer advance.
	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
		ring_next = (p == IDX_W'(SLOTS - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

@@ design/heavy_hitter_counter.sv @@
// Frequent-items table of SLOTS key/counter cells in a row. Every request
// is first captured, then all cells compare the key at once and hand hit
// and read data along the row. A count request that misses a full table
// adds a decay round: every held counter above zero decrements and every
// held counter at zero frees its slot, then the freed slots go onto the
// free list one at a time in ascending order, lowest first through the row,
// and last comes the insert or drop. One request is in work at a time; the
// result waits in an output register and the next request is taken once
// the result is formed.
module heavy_hitter_counter
	import hhc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                operation,
	input  logic [KEY_W-1:0]    item_key,
	input  logic [RD_W-1:0]     slot_index,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STAT_W-1:0]   status,
	output logic                slot_valid,
	output logic [KEY_W-1:0]    slot_key,
	output logic [CNT_W-1:0]    slot_count,
	output logic [USED_W-1:0]   occupied
);

	hhc_state_t state_q, state_d;

	logic             op_q;
	logic [KEY_W-1:0] key_q;
	logic [RD_W-1:0]  idx_q;

	logic [IDX_W-1:0]  free_q [SLOTS];
	logic [IDX_W-1:0]  head_q;
	logic [IDX_W-1:0]  tail_q;
	logic [USED_W-1:0] used_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic              slot_valid_q;
	logic [KEY_W-1:0]  slot_key_q;
	logic [CNT_W-1:0]  slot_count_q;
	logic [USED_W-1:0] occupied_q;

	cell_cmd_t   cmd;
	cell_chain_t chain [SLOTS+1];

	logic              go;
	logic              accept;
	logic              pop;
	logic              push;
	logic              load;
	logic [STAT_W-1:0] ld_status;
	logic              ld_valid;
	logic [KEY_W-1:0]  ld_key;
	logic [CNT_W-1:0]  ld_count;
	logic [USED_W-1:0] ld_occ;
	cell_act_t         act;

	assign go     = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;

	assign cmd.act  = act;
	assign cmd.key  = key_q;
	assign cmd.idx  = idx_q;
	assign cmd.slot = free_q[head_q];

	// Row of slot cells.
	assign chain[0] = '0;
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		hhc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.my_index  (IDX_W'(i)),
			.cmd       (cmd),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, cell action and result formation.
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		act       = CA_NONE;
		pop       = 1'b0;
		push      = 1'b0;
		load      = 1'b0;
		ld_status = ST_DROP;
		ld_valid  = 1'b0;
		ld_key    = '0;
		ld_count  = '0;
		ld_occ    = used_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				if (op_q == OP_READ) begin
					if (go) begin
						load      = 1'b1;
						ld_status = ST_READ;
						ld_valid  = chain[SLOTS].rd_valid;
						ld_key    = chain[SLOTS].rd_key;
						ld_count  = chain[SLOTS].rd_count;
						state_d   = S_IDLE;
					end
				end else if (chain[SLOTS].hit) begin
					if (go) begin
						act       = CA_HIT;
						load      = 1'b1;
						ld_status = ST_HIT;
						state_d   = S_IDLE;
					end
				end else if (used_q < USED_W'(SLOTS)) begin
					if (go) begin
						act       = CA_INSERT;
						pop       = 1'b1;
						load      = 1'b1;
						ld_status = ST_INSERT;
						ld_occ    = used_q + 1'b1;
						state_d   = S_IDLE;
					end
				end else begin
					state_d = S_DECAY;
				end
			end
			S_DECAY: begin
				act     = CA_DECAY;
				state_d = S_PUSH;
			end
			S_PUSH: begin
				if (chain[SLOTS].sel_found) begin
					act  = CA_PUSH;
					push = 1'b1;
				end else if (go) begin
					load    = 1'b1;
					state_d = S_IDLE;
					if (used_q < USED_W'(SLOTS)) begin
						act       = CA_INSERT;
						pop       = 1'b1;
						ld_status = ST_INSERT;
						ld_occ    = used_q + 1'b1;
					end else begin
						ld_status = ST_DROP;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Captured request.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			key_q <= item_key;
			idx_q <= slot_index;
		end
	end

	// Free list ring and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				free_q[i] <= IDX_W'(i);
			end
			head_q <= '0;
			tail_q <= '0;
			used_q <= '0;
		end else begin
			if (push) begin
				free_q[tail_q] <= chain[SLOTS].sel_idx;
				tail_q         <= ring_next(tail_q);
				used_q         <= used_q - 1'b1;
			end else if (pop) begin
				head_q <= ring_next(head_q);
				used_q <= used_q + 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q     <= ld_status;
			slot_valid_q <= ld_valid;
			slot_key_q   <= ld_key;
			slot_count_q <= ld_count;
			occupied_q   <= ld_occ;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign slot_valid = slot_valid_q;
	assign slot_key   = slot_key_q;
	assign slot_count = slot_count_q;
	assign occupied   = occupied_q;

	// The free list is empty when the table is full and full when it is empty.
	a_ring_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q == '0 || used_q == USED_W'(SLOTS)) |-> (head_q == tail_q))
		else $error("free list pointers disagree with occupancy");

	// A decay round only starts on a full table.
	a_decay_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECAY) |-> (used_q == USED_W'(SLOTS)))
		else $error("decay round on a table that is not full");

	// Each freed slot moved onto the free list lowers occupancy by one.
	a_push_used: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (used_q == $past(used_q) - 1'b1))
		else $error("occupancy not lowered by a free list push");

	// Occupancy never exceeds the table size.
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(SLOTS))
		else $error("occupancy out of range");

endmodule

@@ design/hhc_cell.sv @@
module hhc_cell
	import hhc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] my_index,
	input  cell_cmd_t        cmd,
	input  cell_chain_t      chain_in,
	output cell_chain_t      chain_out
);

	logic             in_use_q;
	logic             pend_q;
	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] count_q;

	logic match;
	logic rd_here;
	logic sel_mine;
	logic ins_here;

	assign match    = in_use_q && (key_q == cmd.key);
	assign rd_here  = in_use_q && (cmd.idx == RD_W'(my_index));
	assign sel_mine = pend_q && !chain_in.sel_found;
	assign ins_here = (cmd.slot == my_index);

	// Pass hit, read data and the lowest pending freed slot along the row.
	always_comb begin
		chain_out           = chain_in;
		chain_out.hit       = chain_in.hit | match;
		chain_out.sel_found = chain_in.sel_found | pend_q;
		if (sel_mine) begin
			chain_out.sel_idx = my_index;
		end
		if (rd_here) begin
			chain_out.rd_valid = 1'b1;
			chain_out.rd_key   = key_q;
			chain_out.rd_count = count_q;
		end
	end

	// Slot control state and counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= 1'b0;
			pend_q   <= 1'b0;
			count_q  <= '0;
		end else begin
			unique case (cmd.act)
				CA_HIT: begin
					if (match && count_q != CNT_MAX) begin
						count_q <= count_q + 1'b1;
					end
				end
				CA_INSERT: begin
					if (ins_here) begin
						in_use_q <= 1'b1;
						count_q  <= CNT_W'(1);
					end
				end
				CA_DECAY: begin
					if (in_use_q) begin
						if (count_q == '0) begin
							in_use_q <= 1'b0;
							pend_q   <= 1'b1;
						end else begin
							count_q <= count_q - 1'b1;
						end
					end
				end
				CA_PUSH: begin
					if (sel_mine) begin
						pend_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Key storage is written only on insert and needs no reset.
	always_ff @(posedge clk) begin
		if (cmd.act == CA_INSERT && ins_here) begin
			key_q <= cmd.key;
		end
	end

endmodule

@@ bench/tb_heavy_hitter_counter.sv @@
`timescale 1ns / 100ps

module tb_heavy_hitter_counter;
	import hhc_pkg::*;

	localparam int RANDOM_REQUESTS = 1875;
	localparam int LONG_HOLD       = 80;
	localparam int STALL_LIMIT     = 3000;
	localparam int SETTLE_CYCLES   = 40;

	// One result as the block reports it.
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [CNT_W-1:0]  count;
		logic [USED_W-1:0] occupied;
	} table_result_t;

	// Mirror of the frequent-items table plus the results it still owes.
	class frequency_table_checker;
		logic [KEY_W-1:0]  keys [SLOTS];
		logic [CNT_W-1:0]  counts [SLOTS];
		logic              in_use [SLOTS];
		logic [IDX_W-1:0]  free_ring [SLOTS];
		logic [IDX_W-1:0]  ring_head;
		logic [IDX_W-1:0]  ring_tail;
		int unsigned       held;
		table_result_t     pending_results[$];
		int                errors;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				keys[i] = '0;
				counts[i] = '0;
				in_use[i] = 1'b0;
				free_ring[i] = IDX_W'(i);
			end
			ring_head = '0;
			ring_tail = '0;
			held = 0;
			errors = 0;
		endfunction

		function logic [IDX_W-1:0] advance(logic [IDX_W-1:0] p);
			return (p == IDX_W'(SLOTS - 1)) ? '0 : p + 1'b1;
		endfunction

		// Full-table miss: every held counter loses one; counters already at
		// zero free their slot, lowest index first onto the free list.
		function void decay_round();
			for (int i = 0; i < SLOTS; i++) begin
				if (in_use[i]) begin
					if (counts[i] == '0) begin
						in_use[i] = 1'b0;
						free_ring[ring_tail] = IDX_W'(i);
						ring_tail = advance(ring_tail);
						if (held > 0)
							held--;
					end else begin
						counts[i] = counts[i] - 1'b1;
					end
				end
			end
		endfunction

		function logic [STAT_W-1:0] predict_count(logic [KEY_W-1:0] key);
			logic [IDX_W-1:0] slot;
			for (int i = 0; i < SLOTS; i++) begin
				if (in_use[i] && keys[i] == key) begin
					if (counts[i] != CNT_MAX)
						counts[i] = counts[i] + 1'b1;
					return ST_HIT;
				end
			end
			if (held >= SLOTS)
				decay_round();
			if (held < SLOTS) begin
				slot = free_ring[ring_head];
				ring_head = advance(ring_head);
				keys[slot] = key;
				counts[slot] = 1;
				in_use[slot] = 1'b1;
				held++;
				return ST_INSERT;
			end
			return ST_DROP;
		endfunction

		// Called for every accepted request.
		function void note_request(logic op, logic [KEY_W-1:0] key, logic [RD_W-1:0] idx);
			table_result_t r;
			r = '0;
			if (op == OP_READ) begin
				r.status = ST_READ;
				if (int'(idx) < SLOTS && in_use[idx]) begin
					r.valid = 1'b1;
					r.key = keys[idx];
					r.count = counts[idx];
				end
			end else begin
				r.status = predict_count(key);
			end
			r.occupied = USED_W'(held);
			pending_results.push_back(r);
		endfunction

		// Called for every accepted result.
		function void check_result(table_result_t got);
			table_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing outstanding: %p", $time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.valid !== want.valid) begin
				$display("%0t: slot_valid expected %0d, got %0d", $time, want.valid, got.valid);
				errors++;
			end
			if (got.key !== want.key) begin
				$display("%0t: slot_key expected %h, got %h", $time, want.key, got.key);
				errors++;
			end
			if (got.count !== want.count) begin
				$display("%0t: slot_count expected %0d, got %0d", $time, want.count, got.count);
				errors++;
			end
			if (got.occupied !== want.occupied) begin
				$display("%0t: occupied expected %0d, got %0d", $time, want.occupied,
					got.occupied);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              operation = OP_COUNT;
	logic [KEY_W-1:0]  item_key = '0;
	logic [RD_W-1:0]   slot_index = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [STAT_W-1:0] status;
	logic              slot_valid;
	logic [KEY_W-1:0]  slot_key;
	logic [CNT_W-1:0]  slot_count;
	logic [USED_W-1:0] occupied;

	frequency_table_checker sb = new();

	logic              no_idle = 1'b0;
	logic              hold_request = 1'b0;
	logic [KEY_W-1:0]  hot_keys [8];
	logic [KEY_W-1:0]  warm_keys [40];
	int                quiet_cycles = 0;

	heavy_hitter_counter DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.item_key   (item_key),
		.slot_index (slot_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.slot_valid (slot_valid),
		.slot_key   (slot_key),
		.slot_count (slot_count),
		.occupied   (occupied)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Offer one request after a random gap and hold it until it is taken.
	task automatic send_request(logic op, logic [KEY_W-1:0] key, logic [RD_W-1:0] idx);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		item_key <= key;
		slot_index <= idx;
		do @(posedge clk); while (!in_ready);
		sb.note_request(op, key, idx);
	endtask

	// Withdraw the input and wait until every owed result has come back.
	task automatic wait_for_drain();
		if (sb.outstanding() != 0) begin
			in_valid <= 1'b0;
			while (sb.outstanding() != 0) @(posedge clk);
		end
	endtask

	// Directed requests: key extremes, reads of held and free slots, a full
	// table, a decay round that drops, then one that frees and inserts.
	task automatic run_directed();
		send_request(OP_COUNT, 32'h0000_0000, 4'd0);
		send_request(OP_COUNT, 32'hFFFF_FFFF, 4'd15);
		send_request(OP_COUNT, 32'h0000_0000, 4'd7);
		send_request(OP_READ, 32'hFFFF_FFFF, 4'd0);
		send_request(OP_READ, 32'h0000_0000, 4'd1);
		send_request(OP_READ, 32'h1234_5678, 4'd15);
		for (int i = 0; i < 14; i++)
			send_request(OP_COUNT, 32'h5A5A_0000 + 32'(i), 4'(i));
		send_request(OP_COUNT, 32'hC001_0001, 4'd3);
		send_request(OP_COUNT, 32'hC001_0002, 4'd9);
		send_request(OP_READ, 32'h0, 4'd0);
		send_request(OP_COUNT, 32'hC001_0003, 4'd12);
		send_request(OP_READ, 32'h0, 4'd1);
	endtask

	// Mostly a small set of frequent keys so the table fills, hits and
	// decays; a wider set forces misses, and a few keys are fully random.
	task automatic run_random();
		int pick;
		logic [KEY_W-1:0] key;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 100 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if (n == 600) begin
				no_idle = 1'b1;
				hold_request = 1'b1;
			end
			if (n == 1200)
				wait_for_drain();
			pick = $urandom_range(0, 99);
			if (pick < 60)
				key = hot_keys[$urandom_range(0, 7) & $urandom_range(0, 7)];
			else if (pick < 90)
				key = warm_keys[$urandom_range(0, 39)];
			else
				key = $urandom;
			send_request(($urandom_range(0, 99) < 22) ? OP_READ : OP_COUNT, key,
				RD_W'($urandom_range(0, 15)));
		end
	endtask

	// Result side: random stalls, calm stretches and one long hold-off.
	initial begin
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				stall = LONG_HOLD;
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, 6);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Check every accepted result against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({status, slot_valid, slot_key, slot_count, occupied});
	end

	// Watchdog on cycles with no request or result accepted.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < 8; i++)
			hot_keys[i] = $urandom;
		for (int i = 0; i < 40; i++)
			warm_keys[i] = $urandom;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		wait_for_drain();
		run_random();
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
